// ===== design/ipd_pe_pkg.sv =====
// Package with the word types, parser phases and character constants of the IPD payload extractor.
package ipd_pe_pkg;

  // Default width of the decimal length counter.
  localparam int unsigned LengthBitsDefault = 16;

  // Width of the max_payload register.
  localparam int unsigned MaxPayloadBits = 16;

  // Reset value of max_payload.
  localparam logic [MaxPayloadBits-1:0] MaxPayloadReset = 16'd99;

  // The header "IPD," as four bytes, first byte in the top position.
  localparam logic [31:0] HdrWord = 32'h4950_442C;

  // Character codes used by the length parser.
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] DigitMax  = 8'd9;

  // Input word modes.
  typedef enum logic {
    MODE_BYTE    = 1'b0,
    MODE_RELEASE = 1'b1
  } ipd_mode_e;

  // Parser phases; the unused code behaves as header search.
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2
  } ipd_phase_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } ipd_in_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last;
    logic       too_long;
  } ipd_out_t;

endpackage

// ===== design/ipd_payload_extractor_top.sv =====
// Top level of the IPD payload extractor: input register, parser and result register.
//
// The block watches a stream of received bytes for the header "IPD,", a decimal
// length and a colon, then passes the following payload bytes out one per word.
// Input channel (in_valid_i / in_ready_o / in_data_i): each word is either a
// received byte (mode 0) or a release (mode 1) that frees a held frame and resets
// the parser. Output channel (out_valid_o / out_ready_i / out_data_o): one word
// per payload byte with last set on the final one, or a single error word with
// too_long set when the announced length exceeds max_payload.
// Configuration channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes
// max_payload; it is always ready and should only be used while the block is idle.
// An accepted input word stands in the input register; the parser works on it
// combinationally once the result register is free or being emptied, and writes
// its result into the result register. Throughput is one word per cycle while the
// receiver does not stall: the input register feeds the parser, which writes the result register.
// When the receiver stalls, the result register holds its word and the input
// register holds the next one; in_ready_o drops only when both are full.
// Reset clears the parser to header search, releases any held frame, empties
// both registers and sets max_payload back to 99.
module ipd_payload_extractor_top #(
  parameter int unsigned LengthBits = ipd_pe_pkg::LengthBitsDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  ipd_pe_pkg::ipd_in_t                   in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output ipd_pe_pkg::ipd_out_t                  out_data_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ipd_pe_pkg::MaxPayloadBits-1:0] cfg_data_i
);

  // The remaining counter holds one more bit so that a saturated length
  // (2^LengthBits) can be told apart from every legal one.
  localparam int unsigned RemW = LengthBits + 1;
  // Width of remaining * 10 + digit before saturation.
  localparam int unsigned MulW = LengthBits + 5;
  // Width used to compare the length against max_payload.
  localparam int unsigned CmpW = (RemW > ipd_pe_pkg::MaxPayloadBits) ?
                                 RemW : ipd_pe_pkg::MaxPayloadBits;

  localparam logic [RemW-1:0] RemSat = RemW'(1) << LengthBits;
  localparam logic [MulW-1:0] MulSat = MulW'(1) << LengthBits;

  // Input register.
  logic                 in_valid_q;
  ipd_pe_pkg::ipd_in_t  in_q;

  // Result register.
  logic                 out_valid_q;
  ipd_pe_pkg::ipd_out_t out_q;

  // Configuration.
  logic [ipd_pe_pkg::MaxPayloadBits-1:0] max_q;

  // Parser state.
  logic [31:0]            hdr_q, hdr_d;
  ipd_pe_pkg::ipd_phase_e phase_q, phase_d;
  logic [RemW-1:0]        rem_q, rem_d;
  logic                   hold_q, hold_d;

  // Result of the word being parsed.
  logic                 res_valid;
  ipd_pe_pkg::ipd_out_t res;

  logic            fire;
  logic            is_digit;
  logic [7:0]      digit_raw;
  logic [MulW-1:0] rem_ext;
  logic [MulW-1:0] rem_mul;
  logic [RemW-1:0] rem_dec;
  logic [31:0]     hdr_shift;
  logic            len_too_long;

  // The parser takes the registered word whenever the result register is free
  // or is being emptied in this cycle.
  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // Shared datapath pieces.
  assign digit_raw = in_q.data_byte - ipd_pe_pkg::CharZero;
  assign is_digit  = (in_q.data_byte >= ipd_pe_pkg::CharZero) &&
                     (digit_raw <= ipd_pe_pkg::DigitMax);
  assign rem_ext   = MulW'(rem_q);
  // remaining * 10 + digit, built from two shifts.
  assign rem_mul   = (rem_ext << 3) + (rem_ext << 1) + MulW'(digit_raw[3:0]);
  assign rem_dec   = (rem_q != '0) ? (rem_q - RemW'(1)) : rem_q;
  assign hdr_shift = {hdr_q[23:0], in_q.data_byte};
  // A saturated length is always too long.
  assign len_too_long = rem_q[LengthBits] || (CmpW'(rem_q) > CmpW'(max_q));

  // Parser: next state and result for the registered word.
  always_comb begin
    hdr_d     = hdr_q;
    phase_d   = phase_q;
    rem_d     = rem_q;
    hold_d    = hold_q;
    res_valid = 1'b0;
    res       = '0;
    if (fire) begin
      if (in_q.mode == ipd_pe_pkg::MODE_RELEASE) begin
        hdr_d   = '0;
        rem_d   = '0;
        phase_d = ipd_pe_pkg::PH_HEADER;
        hold_d  = 1'b0;
      end else if (!hold_q) begin
        case (phase_q)
          ipd_pe_pkg::PH_LENGTH: begin
            if (in_q.data_byte == ipd_pe_pkg::CharColon) begin
              if (rem_q == '0) begin
                hdr_d   = '0;
                rem_d   = '0;
                phase_d = ipd_pe_pkg::PH_HEADER;
              end else if (len_too_long) begin
                hdr_d        = '0;
                rem_d        = '0;
                phase_d      = ipd_pe_pkg::PH_HEADER;
                res_valid    = 1'b1;
                res.too_long = 1'b1;
              end else begin
                phase_d = ipd_pe_pkg::PH_PAYLOAD;
              end
            end else if (is_digit) begin
              rem_d = (rem_mul >= MulSat) ? RemSat : RemW'(rem_mul);
            end else begin
              hdr_d   = '0;
              rem_d   = '0;
              phase_d = ipd_pe_pkg::PH_HEADER;
            end
          end
          ipd_pe_pkg::PH_PAYLOAD: begin
            res_valid        = 1'b1;
            res.payload_byte = in_q.data_byte;
            res.last         = (rem_dec == '0);
            rem_d            = rem_dec;
            if (rem_dec == '0) begin
              hold_d  = 1'b1;
              hdr_d   = '0;
              phase_d = ipd_pe_pkg::PH_HEADER;
            end
          end
          default: begin
            // Header search.
            phase_d = ipd_pe_pkg::PH_HEADER;
            hdr_d   = hdr_shift;
            if (hdr_shift == ipd_pe_pkg::HdrWord) begin
              hdr_d   = '0;
              rem_d   = '0;
              phase_d = ipd_pe_pkg::PH_LENGTH;
            end
          end
        endcase
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      max_q       <= ipd_pe_pkg::MaxPayloadReset;
      hdr_q       <= '0;
      phase_q     <= ipd_pe_pkg::PH_HEADER;
      rem_q       <= '0;
      hold_q      <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (fire) begin
        out_valid_q <= res_valid;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        max_q <= cfg_data_i;
      end
      hdr_q   <= hdr_d;
      phase_q <= phase_d;
      rem_q   <= rem_d;
      hold_q  <= hold_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      in_q <= in_data_i;
    end
    if (fire) begin
      out_q <= res;
    end
  end

`ifndef SYNTHESIS
  // An error word never marks the end of a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.too_long && out_data_o.last))
    else $error("error word carries last");

  // A held frame always leaves the parser in header search.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q |-> (phase_q == ipd_pe_pkg::PH_HEADER))
    else $error("holding outside header search");

  // While passing payload there is always at least one byte left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == ipd_pe_pkg::PH_PAYLOAD) |-> (rem_q != '0))
    else $error("payload phase with zero bytes left");

  // A release clears the hold and returns to header search.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (in_q.mode == ipd_pe_pkg::MODE_RELEASE)) |=>
      (!hold_q && (phase_q == ipd_pe_pkg::PH_HEADER) && (rem_q == '0)))
    else $error("release did not reset the parser");

  // With both registers full and the receiver stalled, no new word is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while pipeline is full");
`endif

endmodule
